### rtl/i2cm_pkg.sv
`default_nettype none
package i2cm_pkg;

    localparam int COUNT_BITS = 8;

    localparam logic [7:0] BIT_EA  = 8'h40;
    localparam logic [7:0] BIT_STA = 8'h20;
    localparam logic [7:0] BIT_STO = 8'h10;

    localparam logic [3:0] EV_START       = 4'd0;
    localparam logic [3:0] EV_REPSTART    = 4'd1;
    localparam logic [3:0] EV_MT_SLA_ACK  = 4'd2;
    localparam logic [3:0] EV_MT_DATA_ACK = 4'd3;
    localparam logic [3:0] EV_MR_SLA_ACK  = 4'd4;
    localparam logic [3:0] EV_MR_DATA_ACK = 4'd5;
    localparam logic [3:0] EV_MR_DATA_NACK = 4'd6;
    localparam logic [3:0] EV_MR_SLA_NACK = 4'd7;
    localparam logic [3:0] EV_MT_SLA_NACK = 4'd8;
    localparam logic [3:0] EV_MT_DATA_NACK = 4'd9;
    localparam logic [3:0] EV_ARB_LOST    = 4'd10;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NACK = 2'd1;
    localparam logic [1:0] ST_ARB  = 2'd2;

    typedef struct packed {
        logic [3:0] status_event;
        logic [7:0] control_in;
        logic [7:0] rx_byte;
        logic [7:0] tx_byte;
        logic [6:0] new_address;
        logic [7:0] new_write_count;
        logic [7:0] new_read_count;
        logic       queue_has_more;
    } t_event;

    typedef struct packed {
        logic [7:0] control_out;
        logic [7:0] data_out;
        logic       data_write;
        logic       tx_pop;
        logic [7:0] tx_flush_count;
        logic       rx_push;
        logic       done_res;
        logic [1:0] done_status;
        logic       bus_active;
        logic       fault;
    } t_result;

endpackage
`default_nettype wire

### rtl/i2cm_core.sv
`default_nettype none
module i2cm_core (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_accept,
    input  i2cm_pkg::t_event       i_event,
    output i2cm_pkg::t_result      o_result
);

    localparam int CW = i2cm_pkg::COUNT_BITS;

    logic [6:0]    r_address, n_address;
    logic [CW-1:0] r_writes, n_writes;
    logic [CW-1:0] r_reads, n_reads;
    logic          r_active, n_active;

    logic [6:0]    w_addr;
    logic [CW-1:0] w_writes;
    logic [CW-1:0] w_reads;
    logic [CW-1:0] w_reads_dec;
    logic [7:0]    w_flush;
    logic [7:0]    w_ctl;
    logic          w_fin;
    logic [1:0]    w_fin_status;
    i2cm_pkg::t_result w_res;

    always_comb begin
        w_addr      = (i_event.status_event == i2cm_pkg::EV_START) ?
                      i_event.new_address : r_address;
        w_writes    = (i_event.status_event == i2cm_pkg::EV_START) ?
                      CW'(i_event.new_write_count) : r_writes;
        w_reads     = (i_event.status_event == i2cm_pkg::EV_START) ?
                      CW'(i_event.new_read_count) : r_reads;
        w_reads_dec = r_reads - CW'(1);
        w_flush     = (32'(r_writes) > 32'd255) ? 8'hFF : 8'(r_writes);
    end

    always_comb begin
        n_address    = w_addr;
        n_writes     = w_writes;
        n_reads      = w_reads;
        n_active     = r_active;
        w_ctl        = i_event.control_in;
        w_fin        = 1'b0;
        w_fin_status = i2cm_pkg::ST_OK;
        w_res        = '0;
        unique case (i_event.status_event) inside
            i2cm_pkg::EV_START, i2cm_pkg::EV_REPSTART: begin
                if (i_event.status_event == i2cm_pkg::EV_START) begin
                    n_active = 1'b1;
                end
                w_ctl            = w_ctl & ~i2cm_pkg::BIT_STA;
                w_res.data_out   = {w_addr, (w_reads != '0) && (w_writes == '0)};
                w_res.data_write = 1'b1;
            end
            i2cm_pkg::EV_MT_SLA_ACK, i2cm_pkg::EV_MT_DATA_ACK: begin
                if (r_writes != '0) begin
                    n_writes         = r_writes - CW'(1);
                    w_res.data_out   = i_event.tx_byte;
                    w_res.data_write = 1'b1;
                    w_res.tx_pop     = 1'b1;
                end else if (r_reads != '0) begin
                    w_ctl = w_ctl | i2cm_pkg::BIT_STA;
                end else begin
                    w_fin = 1'b1;
                end
            end
            i2cm_pkg::EV_MR_SLA_ACK: begin
                if (r_reads > CW'(1)) begin
                    w_ctl = w_ctl | i2cm_pkg::BIT_EA;
                end
            end
            i2cm_pkg::EV_MR_DATA_ACK, i2cm_pkg::EV_MR_DATA_NACK: begin
                w_res.rx_push = 1'b1;
                n_reads       = w_reads_dec;
                if (w_reads_dec == CW'(1)) begin
                    w_ctl = w_ctl & ~i2cm_pkg::BIT_EA;
                end else if (w_reads_dec == '0) begin
                    w_fin = 1'b1;
                end
            end
            i2cm_pkg::EV_MR_SLA_NACK: begin
                w_fin        = 1'b1;
                w_fin_status = i2cm_pkg::ST_NACK;
            end
            i2cm_pkg::EV_MT_SLA_NACK, i2cm_pkg::EV_MT_DATA_NACK: begin
                w_res.tx_flush_count = w_flush;
                w_fin                = 1'b1;
                w_fin_status         = i2cm_pkg::ST_NACK;
            end
            i2cm_pkg::EV_ARB_LOST: begin
                w_res.tx_flush_count = w_flush;
                w_fin                = 1'b1;
                w_fin_status         = i2cm_pkg::ST_ARB;
            end
            default: begin
                w_res.fault = 1'b1;
                n_active    = 1'b0;
            end
        endcase
        if (w_fin) begin
            w_ctl             = w_ctl | i2cm_pkg::BIT_STO;
            w_res.done_res    = 1'b1;
            w_res.done_status = w_fin_status;
            if (i_event.queue_has_more) begin
                w_ctl = w_ctl | i2cm_pkg::BIT_STA;
            end else begin
                n_active = 1'b0;
            end
        end
        if (i_event.status_event == i2cm_pkg::EV_ARB_LOST) begin
            w_ctl = w_ctl & ~i2cm_pkg::BIT_STO;
        end
        w_res.control_out = w_ctl;
        w_res.bus_active  = n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address <= '0;
            r_writes  <= '0;
            r_reads   <= '0;
            r_active  <= 1'b0;
        end else if (i_accept) begin
            r_address <= n_address;
            r_writes  <= n_writes;
            r_reads   <= n_reads;
            r_active  <= n_active;
        end
    end

    assign o_result = w_res;

    a_fault_drops_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && w_res.fault) |=> !r_active)
        else $error("fault left bus active");

    a_start_sets_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_event.status_event == i2cm_pkg::EV_START) |=> r_active)
        else $error("start did not activate bus");

endmodule
`default_nettype wire

### rtl/i2cm_out_buf.sv
`default_nettype none
module i2cm_out_buf (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_accept,
    input  i2cm_pkg::t_result      i_result,
    input  wire                    i_stall,
    output logic                   o_valid,
    output logic                   o_full,
    output i2cm_pkg::t_result      o_result
);

    logic              r_out_valid;
    logic              r_skid_valid;
    i2cm_pkg::t_result r_out;
    i2cm_pkg::t_result r_skid;
    logic              w_take;
    logic              w_to_skid;

    assign w_take    = r_out_valid && !i_stall;
    assign w_to_skid = i_accept && r_out_valid && !w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_accept) begin
            if (w_to_skid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            if (w_to_skid) begin
                r_skid <= i_result;
            end else begin
                r_out <= i_result;
            end
        end else if (w_take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_full   = r_skid_valid;
    assign o_result = r_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a transaction ahead of output");

    a_stalled_accept_parks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_out_valid && i_stall) |=> (r_skid_valid && r_out_valid))
        else $error("transaction lost while output stalled");

endmodule
`default_nettype wire

### rtl/i2c_master_transaction_sequencer.sv
`default_nettype none
// Two-wire bus master transaction sequencer.
// Input channel: one bus status event per transaction on i_valid / o_stall,
// with the current control byte, received byte, transmit FIFO head and, on
// a start event, the new target address and write / read counts.
// Output channel: o_valid / i_stall, one result per event: control byte to
// write back, data register byte and write strobe, FIFO pop / push / flush
// requests, completion flag and status, bus activity and fault.
// Each accepted event's result is registered, in the output stage or the
// skid stage. Throughput: one event per cycle while o_stall is low, as the
// address and count registers are updated on every accepted event.
// Reset (synchronous, active low) clears the address, counts, active flag
// and both output stages.
// When the receiver stalls, the held result stays unchanged and one more
// event is taken into a skid stage; o_stall rises only while that stage is
// occupied and drops the cycle after the receiver takes the held result.
module i2c_master_transaction_sequencer (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_stall,
    input  wire  [3:0] i_status_event,
    input  wire  [7:0] i_control_in,
    input  wire  [7:0] i_rx_byte,
    input  wire  [7:0] i_tx_byte,
    input  wire  [6:0] i_new_address,
    input  wire  [7:0] i_new_write_count,
    input  wire  [7:0] i_new_read_count,
    input  wire        i_queue_has_more,
    output logic       o_valid,
    input  wire        i_stall,
    output logic [7:0] o_control_out,
    output logic [7:0] o_data_out,
    output logic       o_data_write,
    output logic       o_tx_pop,
    output logic [7:0] o_tx_flush_count,
    output logic       o_rx_push,
    output logic       o_done_res,
    output logic [1:0] o_done_status,
    output logic       o_bus_active,
    output logic       o_fault
);

    i2cm_pkg::t_event  w_event;
    i2cm_pkg::t_result w_result;
    i2cm_pkg::t_result w_out;
    logic              w_full;
    logic              w_accept;

    assign w_event = '{
        status_event:    i_status_event,
        control_in:      i_control_in,
        rx_byte:         i_rx_byte,
        tx_byte:         i_tx_byte,
        new_address:     i_new_address,
        new_write_count: i_new_write_count,
        new_read_count:  i_new_read_count,
        queue_has_more:  i_queue_has_more
    };

    assign o_stall  = w_full;
    assign w_accept = i_valid && !w_full;

    i2cm_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_event  (w_event),
        .o_result (w_result)
    );

    i2cm_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_result (w_result),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_full   (w_full),
        .o_result (w_out)
    );

    assign o_control_out    = w_out.control_out;
    assign o_data_out       = w_out.data_out;
    assign o_data_write     = w_out.data_write;
    assign o_tx_pop         = w_out.tx_pop;
    assign o_tx_flush_count = w_out.tx_flush_count;
    assign o_rx_push        = w_out.rx_push;
    assign o_done_res       = w_out.done_res;
    assign o_done_status    = w_out.done_status;
    assign o_bus_active     = w_out.bus_active;
    assign o_fault          = w_out.fault;

endmodule
`default_nettype wire

### dv/i2cm_result_checker.sv
`timescale 1ns / 100ps
module i2cm_result_checker (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_ev_valid,
    input  wire               i_ev_stall,
    input  i2cm_pkg::t_event  i_event,
    input  wire               i_res_valid,
    input  wire               i_res_stall,
    input  i2cm_pkg::t_result i_result,
    output int                o_errors,
    output int                o_pending,
    output int                o_checked,
    output int                o_closed
);

    logic [6:0] slave_addr;
    logic [7:0] wr_remaining;
    logic [7:0] rd_remaining;
    logic       bus_busy;

    i2cm_pkg::t_result pending_results[$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
        o_closed  = 0;
    end

    function automatic i2cm_pkg::t_result next_bus_result(input i2cm_pkg::t_event e);
        i2cm_pkg::t_result r;
        logic [7:0]        ctl;
        logic              fin;
        logic [1:0]        fin_status;
        r          = '0;
        ctl        = e.control_in;
        fin        = 1'b0;
        fin_status = i2cm_pkg::ST_OK;
        case (e.status_event)
            i2cm_pkg::EV_START, i2cm_pkg::EV_REPSTART: begin
                if (e.status_event == i2cm_pkg::EV_START) begin
                    slave_addr   = e.new_address;
                    wr_remaining = e.new_write_count;
                    rd_remaining = e.new_read_count;
                    bus_busy     = 1'b1;
                end
                ctl          = ctl & ~i2cm_pkg::BIT_STA;
                r.data_out   = {slave_addr, (rd_remaining != 8'd0 && wr_remaining == 8'd0)};
                r.data_write = 1'b1;
            end
            i2cm_pkg::EV_MT_SLA_ACK, i2cm_pkg::EV_MT_DATA_ACK: begin
                if (wr_remaining != 8'd0) begin
                    wr_remaining = wr_remaining - 8'd1;
                    r.data_out   = e.tx_byte;
                    r.data_write = 1'b1;
                    r.tx_pop     = 1'b1;
                end else if (rd_remaining != 8'd0) begin
                    ctl = ctl | i2cm_pkg::BIT_STA;
                end else begin
                    fin = 1'b1;
                end
            end
            i2cm_pkg::EV_MR_SLA_ACK: begin
                if (rd_remaining > 8'd1)
                    ctl = ctl | i2cm_pkg::BIT_EA;
            end
            i2cm_pkg::EV_MR_DATA_ACK, i2cm_pkg::EV_MR_DATA_NACK: begin
                r.rx_push    = 1'b1;
                rd_remaining = rd_remaining - 8'd1;
                if (rd_remaining == 8'd1)
                    ctl = ctl & ~i2cm_pkg::BIT_EA;
                else if (rd_remaining == 8'd0)
                    fin = 1'b1;
            end
            i2cm_pkg::EV_MR_SLA_NACK: begin
                fin        = 1'b1;
                fin_status = i2cm_pkg::ST_NACK;
            end
            i2cm_pkg::EV_MT_SLA_NACK, i2cm_pkg::EV_MT_DATA_NACK: begin
                r.tx_flush_count = wr_remaining;
                fin              = 1'b1;
                fin_status       = i2cm_pkg::ST_NACK;
            end
            i2cm_pkg::EV_ARB_LOST: begin
                r.tx_flush_count = wr_remaining;
                fin              = 1'b1;
                fin_status       = i2cm_pkg::ST_ARB;
            end
            default: begin
                r.fault  = 1'b1;
                bus_busy = 1'b0;
            end
        endcase
        if (fin) begin
            ctl = ctl | i2cm_pkg::BIT_STO;
            if (e.queue_has_more)
                ctl = ctl | i2cm_pkg::BIT_STA;
            else
                bus_busy = 1'b0;
            if (fin_status == i2cm_pkg::ST_ARB)
                ctl = ctl & ~i2cm_pkg::BIT_STO;
            r.done_res    = 1'b1;
            r.done_status = fin_status;
        end
        r.control_out = ctl;
        r.bus_active  = bus_busy;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        i2cm_pkg::t_result want;
        if (!i_rst_n) begin
            slave_addr   = '0;
            wr_remaining = '0;
            rd_remaining = '0;
            bus_busy     = 1'b0;
            pending_results.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result with no transaction pending");
                    o_errors++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("control_out", 32'(want.control_out),
                                32'(i_result.control_out));
                    check_field("data_out", 32'(want.data_out), 32'(i_result.data_out));
                    check_field("data_write", 32'(want.data_write),
                                32'(i_result.data_write));
                    check_field("tx_pop", 32'(want.tx_pop), 32'(i_result.tx_pop));
                    check_field("tx_flush_count", 32'(want.tx_flush_count),
                                32'(i_result.tx_flush_count));
                    check_field("rx_push", 32'(want.rx_push), 32'(i_result.rx_push));
                    check_field("done_res", 32'(want.done_res), 32'(i_result.done_res));
                    check_field("done_status", 32'(want.done_status),
                                32'(i_result.done_status));
                    check_field("bus_active", 32'(want.bus_active),
                                32'(i_result.bus_active));
                    check_field("fault", 32'(want.fault), 32'(i_result.fault));
                    o_checked++;
                    if (want.done_res)
                        o_closed++;
                end
            end
            if (i_ev_valid && !i_ev_stall)
                pending_results.push_back(next_bus_result(i_event));
        end
        o_pending = pending_results.size();
    end

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
module testbench;

    localparam logic [3:0] EV_OTHER = 4'd11;
    localparam logic [3:0] EV_LAST  = 4'd15;
    localparam int RANDOM_ITEMS = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 600000;

    logic             clk;
    logic             rst_n;
    logic             ev_valid;
    logic             res_stall;
    wire              ev_stall;
    wire              res_valid;
    i2cm_pkg::t_event stim;

    wire [7:0] res_control;
    wire [7:0] res_data;
    wire       res_data_write;
    wire       res_tx_pop;
    wire [7:0] res_flush;
    wire       res_rx_push;
    wire       res_done;
    wire [1:0] res_done_status;
    wire       res_bus_active;
    wire       res_fault;
    i2cm_pkg::t_result res;

    int   n_errors;
    int   n_pending;
    int   n_checked;
    int   n_closed;
    int   n_sent;
    int   cycle_count;
    logic burst;
    logic holding;
    logic press_req;

    assign res = {res_control, res_data, res_data_write, res_tx_pop, res_flush, res_rx_push,
                  res_done, res_done_status, res_bus_active, res_fault};

    i2c_master_transaction_sequencer dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_valid           (ev_valid),
        .o_stall           (ev_stall),
        .i_status_event    (stim.status_event),
        .i_control_in      (stim.control_in),
        .i_rx_byte         (stim.rx_byte),
        .i_tx_byte         (stim.tx_byte),
        .i_new_address     (stim.new_address),
        .i_new_write_count (stim.new_write_count),
        .i_new_read_count  (stim.new_read_count),
        .i_queue_has_more  (stim.queue_has_more),
        .o_valid           (res_valid),
        .i_stall           (res_stall),
        .o_control_out     (res_control),
        .o_data_out        (res_data),
        .o_data_write      (res_data_write),
        .o_tx_pop          (res_tx_pop),
        .o_tx_flush_count  (res_flush),
        .o_rx_push         (res_rx_push),
        .o_done_res        (res_done),
        .o_done_status     (res_done_status),
        .o_bus_active      (res_bus_active),
        .o_fault           (res_fault)
    );

    i2cm_result_checker checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_ev_valid  (ev_valid),
        .i_ev_stall  (ev_stall),
        .i_event     (stim),
        .i_res_valid (res_valid),
        .i_res_stall (res_stall),
        .i_result    (res),
        .o_errors    (n_errors),
        .o_pending   (n_pending),
        .o_checked   (n_checked),
        .o_closed    (n_closed)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial cycle_count = 0;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[i2c_master_transaction_sequencer] ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (burst || holding)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_count();
        int r;
        r = $urandom_range(0, 199);
        if (r < 2)
            return 8'($urandom_range(100, 255));
        if (r < 40)
            return 8'd0;
        return 8'($urandom_range(1, 5));
    endfunction

    function automatic logic [3:0] pick_fault_event();
        case ($urandom_range(0, 5))
            0:       return i2cm_pkg::EV_MR_SLA_NACK;
            1:       return i2cm_pkg::EV_MT_SLA_NACK;
            2:       return i2cm_pkg::EV_MT_DATA_NACK;
            3:       return i2cm_pkg::EV_ARB_LOST;
            4:       return i2cm_pkg::EV_MR_DATA_NACK;
            default: return 4'($urandom_range(EV_OTHER, EV_LAST));
        endcase
    endfunction

    task automatic put_event(input logic [3:0] ev, input logic [7:0] ctl,
                             input logic [6:0] addr, input logic [7:0] wcnt,
                             input logic [7:0] rcnt);
        int               gap;
        i2cm_pkg::t_event e;
        gap               = pick_gap();
        e.status_event    = ev;
        e.control_in      = ctl;
        e.rx_byte         = 8'($urandom);
        e.tx_byte         = 8'($urandom);
        e.new_address     = addr;
        e.new_write_count = wcnt;
        e.new_read_count  = rcnt;
        e.queue_has_more  = 1'($urandom_range(0, 1));
        @(negedge clk);
        if (gap > 0) begin
            ev_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        stim     <= e;
        ev_valid <= 1'b1;
        do @(posedge clk); while (ev_stall);
        n_sent++;
    endtask

    task automatic run_transaction();
        logic [3:0] seq[$];
        logic [6:0] addr;
        logic [7:0] wcnt;
        logic [7:0] rcnt;
        int         cut;
        addr = 7'($urandom);
        wcnt = pick_count();
        rcnt = pick_count();
        seq.push_back(i2cm_pkg::EV_START);
        if (wcnt != 8'd0) begin
            seq.push_back(i2cm_pkg::EV_MT_SLA_ACK);
            repeat (wcnt) seq.push_back(i2cm_pkg::EV_MT_DATA_ACK);
        end
        if (rcnt != 8'd0) begin
            if (wcnt != 8'd0)
                seq.push_back(i2cm_pkg::EV_REPSTART);
            seq.push_back(i2cm_pkg::EV_MR_SLA_ACK);
            repeat (rcnt - 1) seq.push_back(i2cm_pkg::EV_MR_DATA_ACK);
            seq.push_back(i2cm_pkg::EV_MR_DATA_NACK);
        end else if (wcnt == 8'd0) begin
            seq.push_back(i2cm_pkg::EV_MT_SLA_ACK);
        end
        // break the sequence off with an error event somewhere after the start
        if ($urandom_range(0, 3) == 0) begin
            cut = $urandom_range(1, seq.size() - 1);
            while (seq.size() > cut + 1)
                void'(seq.pop_back());
            seq[cut] = pick_fault_event();
        end
        foreach (seq[k])
            put_event(seq[k], 8'($urandom), addr, wcnt, rcnt);
    endtask

    initial begin
        int  run;
        logic level;
        logic press_done;
        run        = 0;
        level      = 1'b0;
        press_done = 1'b0;
        holding    = 1'b0;
        res_stall  = 1'b0;
        forever begin
            @(negedge clk);
            if (press_req && !press_done) begin
                press_done = 1'b1;
                holding    = 1'b1;
                level      = 1'b1;
                run        = HOLD_CYCLES;
            end else if (run == 0) begin
                holding = 1'b0;
                level   = !level;
                if (!level)
                    run = $urandom_range(1, 60);
                else if ($urandom_range(0, 99) < 85)
                    run = $urandom_range(1, 3);
                else
                    run = $urandom_range(10, 40);
            end
            run--;
            res_stall <= level;
        end
    end

    initial begin
        int n_directed;
        rst_n     = 1'b0;
        ev_valid  = 1'b0;
        stim      = '0;
        burst     = 1'b0;
        press_req = 1'b0;
        n_sent    = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // write one, read one, then a completed read
        put_event(i2cm_pkg::EV_START,        8'hFF, 7'h7F, 8'd1, 8'd1);
        put_event(i2cm_pkg::EV_MT_SLA_ACK,   8'hFF, 7'h00, 8'd0, 8'd0);
        put_event(i2cm_pkg::EV_MT_DATA_ACK,  8'h00, 7'h00, 8'd0, 8'd0);
        put_event(i2cm_pkg::EV_REPSTART,     8'hFF, 7'h7F, 8'hFF, 8'hFF);
        put_event(i2cm_pkg::EV_MR_SLA_ACK,   8'h00, 7'h00, 8'd0, 8'd0);
        put_event(i2cm_pkg::EV_MR_DATA_NACK, 8'hFF, 7'h00, 8'd0, 8'd0);
        // empty transaction, then receive with nothing left to read
        put_event(i2cm_pkg::EV_START,        8'h00, 7'h00, 8'd0, 8'd0);
        put_event(i2cm_pkg::EV_MT_SLA_ACK,   8'h00, 7'h00, 8'd0, 8'd0);
        put_event(i2cm_pkg::EV_MR_DATA_ACK,  8'hFF, 7'h7F, 8'hFF, 8'hFF);
        // full counts, nack mid-write and lost arbitration flush
        put_event(i2cm_pkg::EV_START,        8'h00, 7'h55, 8'd255, 8'd255);
        put_event(i2cm_pkg::EV_MT_DATA_ACK,  8'($urandom), 7'h00, 8'd0, 8'd0);
        put_event(i2cm_pkg::EV_MT_DATA_NACK, 8'($urandom), 7'h00, 8'd0, 8'd0);
        put_event(i2cm_pkg::EV_START,        8'hFF, 7'h2A, 8'd3, 8'd2);
        put_event(i2cm_pkg::EV_ARB_LOST,     8'hFF, 7'h00, 8'd0, 8'd0);
        // read-only transaction with acknowledge toggling
        put_event(i2cm_pkg::EV_START,        8'($urandom), 7'h15, 8'd0, 8'd2);
        put_event(i2cm_pkg::EV_MR_SLA_ACK,   8'h00, 7'h00, 8'd0, 8'd0);
        put_event(i2cm_pkg::EV_MR_DATA_ACK,  8'hFF, 7'h00, 8'd0, 8'd0);
        put_event(i2cm_pkg::EV_MR_DATA_NACK, 8'($urandom), 7'h00, 8'd0, 8'd0);
        // address nacks, unknown events, events while idle
        put_event(i2cm_pkg::EV_MR_SLA_NACK,  8'($urandom), 7'h00, 8'd0, 8'd0);
        put_event(i2cm_pkg::EV_MT_SLA_NACK,  8'($urandom), 7'h00, 8'd0, 8'd0);
        put_event(EV_OTHER,                  8'hFF, 7'h7F, 8'hFF, 8'hFF);
        put_event(EV_LAST,                   8'h00, 7'h00, 8'd0, 8'd0);
        put_event(i2cm_pkg::EV_REPSTART,     8'($urandom), 7'h00, 8'd0, 8'd0);
        put_event(i2cm_pkg::EV_MT_DATA_ACK,  8'($urandom), 7'h00, 8'd0, 8'd0);
        n_directed = n_sent;

        press_req = 1'b1;
        while (n_sent < n_directed + RANDOM_ITEMS) begin
            burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 5))
                    put_event(4'($urandom_range(0, 15)), 8'($urandom), 7'($urandom),
                              8'($urandom), 8'($urandom));
            else
                run_transaction();
        end

        @(negedge clk);
        ev_valid <= 1'b0;
        do @(negedge clk); while (n_pending != 0);
        repeat (8) @(negedge clk);

        $display("Drove %0d bus status events (directed, sequenced and noise) under random gaps",
                 n_sent);
        $display("and stalls; compared %0d results, %0d of them closing a transaction.",
                 n_checked, n_closed);
        if (n_errors == 0)
            $display("[i2c_master_transaction_sequencer] OK");
        else
            $display("[i2c_master_transaction_sequencer] ERROR");
        $finish;
    end

endmodule

### i2c_master_transaction_sequencer.f
rtl/i2cm_pkg.sv
rtl/i2cm_core.sv
rtl/i2cm_out_buf.sv
rtl/i2c_master_transaction_sequencer.sv
dv/i2cm_result_checker.sv
dv/testbench.sv
